### hw/rtl/fasr_pkg.sv
// Package for the fraction add/subtract/reduce block.
// Holds widths, stream data widths, opcodes and the controller/datapath interface structs.
// No dependencies.
package fasr_pkg;

    localparam int OPW      = 16;              // operand width
    localparam int MAGW     = OPW;             // operand magnitude width (up to 2^(OPW-1))
    localparam int PRODW    = 2 * MAGW;        // product magnitude width
    localparam int SUMW     = PRODW + 1;       // numerator magnitude width
    localparam int NUM_W    = 33;
    localparam int DEN_W    = 32;
    localparam int IN_TDATA_W  = ((4 * OPW + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;
    localparam int CNT_W    = $clog2(SUMW + 1);

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;      // capture operands, take magnitudes and signs
        logic mul;       // form the three products
        logic comb;      // combine the cross products
        logic gcd_init;  // set up gcd operands
        logic gcd_step;  // one binary gcd step
        logic div_init;  // set up the two divisions
        logic div_step;  // one restoring division bit
        logic finish;    // asserted with the result load; signs are applied combinationally
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic skip;      // numerator or denominator is zero
        logic gcd_done;
        logic div_done;
    } t_sts;

endpackage

### hw/rtl/fasr_ctrl.sv
// Controller state machine for the fraction add/subtract/reduce block.
// Depends on fasr_pkg.
module fasr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_free,
    output logic              o_out_load,
    output fasr_pkg::t_cmd    o_cmd,
    input  fasr_pkg::t_sts    i_sts
);
    import fasr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_COMB = 8'b0000_0100,
        S_GINI = 8'b0000_1000,
        S_GCD  = 8'b0001_0000,
        S_DINI = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = S_GINI;
            end
            S_GINI: begin
                if (i_sts.skip) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = S_DINI;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DINI: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    o_out_load   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ready only when idle, result loads only when the output slot is free
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> i_out_free)
        else $error("result load while output busy");
    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_MUL))
        else $error("accept did not start work");

endmodule

### hw/rtl/fasr_dp.sv
// Datapath for the fraction add/subtract/reduce block: products, sum,
// iterative binary gcd and two restoring dividers sharing one counter.
// Depends on fasr_pkg.
module fasr_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [fasr_pkg::IN_TDATA_W-1:0]       i_data,
    input  logic                                  i_sub,
    input  fasr_pkg::t_cmd                        i_cmd,
    output fasr_pkg::t_sts                        o_sts,
    output logic signed [fasr_pkg::NUM_W-1:0]     o_num,
    output logic signed [fasr_pkg::DEN_W-1:0]     o_den,
    output logic                                  o_zden
);
    import fasr_pkg::*;

    logic            r_sub;
    logic [MAGW-1:0] r_an, r_ad, r_bn, r_bd;
    logic            r_ann, r_adn, r_bnn, r_bdn;
    logic [PRODW-1:0] r_t1, r_t2;
    logic             r_t1n, r_t2n, r_denn;
    logic [SUMW-1:0]  r_num;
    logic             r_numn;
    logic [PRODW-1:0] r_den;
    // gcd registers
    logic [SUMW-1:0]  r_gx, r_gy;
    logic [CNT_W-1:0] r_k;
    logic             r_gph;     // 0: strip common twos, 1: main loop
    // divider registers
    logic [SUMW-1:0]  r_qn, r_rn;
    logic [SUMW-1:0]  r_qd, r_rd;
    logic [SUMW-1:0]  r_g;
    logic [CNT_W-1:0] r_cnt;

    // operand split
    function automatic logic [MAGW-1:0] f_mag(input logic [OPW-1:0] v);
        logic [MAGW-1:0] m;
        m = v[OPW-1] ? MAGW'(~v + 1'b1) : MAGW'(v);
        return m;
    endfunction

    logic [OPW-1:0] w_an, w_ad, w_bn, w_bd;
    assign w_an = i_data[0*OPW +: OPW];
    assign w_ad = i_data[1*OPW +: OPW];
    assign w_bn = i_data[2*OPW +: OPW];
    assign w_bd = i_data[3*OPW +: OPW];

    // combine step
    logic            w_t2n;
    logic [SUMW-1:0] w_sum;
    logic            w_sumn;
    always_comb begin
        w_t2n = r_sub && (r_t2 != '0) ? ~r_t2n : r_t2n;
        if (r_t1n == w_t2n) begin
            w_sum  = SUMW'(r_t1) + SUMW'(r_t2);
            w_sumn = r_t1n;
        end else if (r_t1 >= r_t2) begin
            w_sum  = SUMW'(r_t1 - r_t2);
            w_sumn = r_t1n;
        end else begin
            w_sum  = SUMW'(r_t2 - r_t1);
            w_sumn = w_t2n;
        end
        if (w_sum == '0) w_sumn = 1'b0;
    end

    // gcd step
    logic            w_gdone;
    logic [SUMW-1:0] w_gdiff;
    assign w_gdone = r_gph && (r_gy == '0) && r_gx[0];
    assign w_gdiff = (r_gx > r_gy) ? r_gx - r_gy : r_gy - r_gx;

    // division step, divisor is gcd
    logic [SUMW:0] w_rn2, w_rd2;
    assign w_rn2 = {r_rn, r_qn[SUMW-1]};
    assign w_rd2 = {r_rd, r_qd[SUMW-1]};

    assign o_sts.skip     = (r_num == '0) || (r_den == '0);
    assign o_sts.gcd_done = w_gdone;
    assign o_sts.div_done = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sub <= i_sub;
            r_an  <= f_mag(w_an);  r_ann <= w_an[OPW-1];
            r_ad  <= f_mag(w_ad);  r_adn <= w_ad[OPW-1];
            r_bn  <= f_mag(w_bn);  r_bnn <= w_bn[OPW-1];
            r_bd  <= f_mag(w_bd);  r_bdn <= w_bd[OPW-1];
        end
        if (i_cmd.mul) begin
            r_t1   <= PRODW'(r_an) * PRODW'(r_bd);
            r_t2   <= PRODW'(r_bn) * PRODW'(r_ad);
            r_den  <= PRODW'(r_ad) * PRODW'(r_bd);
            r_t1n  <= (r_ann != r_bdn) && (r_an != '0) && (r_bd != '0);
            r_t2n  <= (r_bnn != r_adn) && (r_bn != '0) && (r_ad != '0);
            r_denn <= (r_adn != r_bdn) && (r_ad != '0) && (r_bd != '0);
        end
        if (i_cmd.comb) begin
            r_num  <= w_sum;
            r_numn <= w_sumn;
        end
        if (i_cmd.gcd_init) begin
            r_gx  <= r_num;
            r_gy  <= SUMW'(r_den);
            r_k   <= '0;
            r_gph <= 1'b0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_gph) begin
                if (!r_gx[0] && !r_gy[0]) begin
                    r_gx <= r_gx >> 1;
                    r_gy <= r_gy >> 1;
                    r_k  <= r_k + 1'b1;
                end else begin
                    r_gph <= 1'b1;
                end
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else begin
                // both odd, nonzero y
                r_gx <= (r_gx > r_gy) ? r_gy : r_gx;
                r_gy <= w_gdiff;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= r_gx << r_k;
            r_qn  <= r_num;
            r_qd  <= SUMW'(r_den);
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= CNT_W'(SUMW);
        end
        if (i_cmd.div_step) begin
            if (w_rn2 >= {1'b0, r_g}) begin
                r_rn <= SUMW'(w_rn2 - {1'b0, r_g});
                r_qn <= {r_qn[SUMW-2:0], 1'b1};
            end else begin
                r_rn <= w_rn2[SUMW-1:0];
                r_qn <= {r_qn[SUMW-2:0], 1'b0};
            end
            if (w_rd2 >= {1'b0, r_g}) begin
                r_rd <= SUMW'(w_rd2 - {1'b0, r_g});
                r_qd <= {r_qd[SUMW-2:0], 1'b1};
            end else begin
                r_rd <= w_rd2[SUMW-1:0];
                r_qd <= {r_qd[SUMW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // results: quotients when reduced, raw parts when skipped
    logic [SUMW-1:0] w_nm, w_dm;
    assign w_nm = o_sts.skip ? r_num : r_qn;
    assign w_dm = o_sts.skip ? SUMW'(r_den) : r_qd;
    assign o_num  = r_numn ? NUM_W'(~w_nm + 1'b1) : NUM_W'(w_nm);
    assign o_den  = r_denn ? DEN_W'(~w_dm + 1'b1) : DEN_W'(w_dm);
    assign o_zden = (r_den == '0);

    a_gcd_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_init |-> (r_gx != '0))
        else $error("gcd is zero at division");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_init |=> (r_cnt == CNT_W'(SUMW)))
        else $error("division counter not loaded");
    a_zero_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.comb) |-> !(r_numn && r_num == '0))
        else $error("negative zero numerator");

endmodule

### hw/rtl/fraction_add_sub_reduce.sv
// Takes one pair of signed 16-bit fractions and an add/subtract opcode at a
// time and returns the sum or difference over the product denominator,
// reduced by the gcd, with the zero-denominator flag. After an accepted
// transfer the block multiplies, combines the cross products and sets up
// the gcd loop. It then runs the gcd loop to its final check, sets up the
// divider, forms the 33-bit quotients with a final check, and loads the
// result. The binary gcd loop does one shift or subtract per cycle and the
// two quotients are formed one bit per cycle by restoring division against
// the gcd. Zero parts skip both loops. The result is held in an output
// register, so the next item is taken while a result waits, until that
// register is needed.
// Depends on fasr_pkg, fasr_ctrl, fasr_dp.
module fraction_add_sub_reduce (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: a_numerator[15:0], a_denominator[31:16], b_numerator[47:32],
    //        b_denominator[63:48]
    input  logic [fasr_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // tuser: opcode
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: result_numerator[32:0], result_denominator[64:33], zeros above
    output logic [fasr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: zero_denominator
    output logic                                  m_axis_tuser
);
    import fasr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_load, w_free;
    logic signed [NUM_W-1:0] w_num;
    logic signed [DEN_W-1:0] w_den;
    logic w_zden;

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic                   r_zden;

    assign w_free = !r_valid || m_axis_tready;

    fasr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_free),
        .o_out_load (w_load),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    fasr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (s_axis_tdata),
        .i_sub   (s_axis_tuser),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_zden  (w_zden)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (w_load) begin
            r_data <= OUT_TDATA_W'({w_den, w_num});
            r_zden <= w_zden;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_zden;

endmodule
